// File: hdl/ipmi_serial_basic_mode_rx_deframer_assert.svh
// Assertion macros shared by the receive deframer modules.
`ifndef IPMI_SERIAL_BASIC_MODE_RX_DEFRAMER_ASSERT_SVH
`define IPMI_SERIAL_BASIC_MODE_RX_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while out of reset
`define RXD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included
`define RXD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RXD_ASSERT(lbl, prop, msg)

`define RXD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/ipmi_rxd_pkg.sv
// Types and constants of the serial basic-mode receive deframer.
`timescale 1ns / 1ps

package ipmi_rxd_pkg;

  // Framing characters
  localparam logic [7:0] ChStart  = 8'hA0;
  localparam logic [7:0] ChStop   = 8'hA5;
  localparam logic [7:0] ChHand   = 8'hA6;
  localparam logic [7:0] ChEsc    = 8'hAA;
  localparam logic [7:0] ChAttn   = 8'h1B;

  // Escaped forms
  localparam logic [7:0] EscStart = 8'hB0;
  localparam logic [7:0] EscStop  = 8'hB5;
  localparam logic [7:0] EscHand  = 8'hB6;
  localparam logic [7:0] EscEsc   = 8'hBA;
  localparam logic [7:0] EscAttn  = 8'h3B;

  // Frame limits
  localparam int unsigned CountW   = 9;
  localparam logic [CountW-1:0] MaxFrame = 9'd277;
  localparam logic [CountW-1:0] MinFrame = 9'd8;
  localparam logic [CountW-1:0] HdrTrail = 9'd5;
  localparam logic [7:0]        LunMask  = 8'hFC;

  // Result kinds
  localparam int unsigned KindW = 3;
  localparam logic [KindW-1:0] KindData  = 3'd0;
  localparam logic [KindW-1:0] KindOk    = 3'd1;
  localparam logic [KindW-1:0] KindCsum  = 3'd2;
  localparam logic [KindW-1:0] KindProto = 3'd3;
  localparam logic [KindW-1:0] KindAttn  = 3'd4;
  localparam logic [KindW-1:0] KindHand  = 3'd5;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgAttnEnable    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEscAttnEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEscAttnChar   = 2'd2;
  localparam logic [7:0]         EscAttnCharRst   = 8'd71;

  // Byte class decided by the front end
  typedef enum logic [2:0] {
    ClsStart,
    ClsStop,
    ClsHand,
    ClsEsc,
    ClsAttn,
    ClsData
  } cls_e;

  // Classified word passed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [7:0] raw;       // byte as received
    logic [7:0] dec;       // byte after escape decoding
    logic       dec_ok;    // raw is a legal escaped form
    logic       esc_attn;  // raw matches the enabled attention char
  } word_t;

  // One result word
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [7:0]        out_byte;
    logic [5:0]        seq_number;
    logic [CountW-1:0] msg_length;
  } res_t;

endpackage

// File: hdl/ipmi_rxd_front.sv
// Front end: configuration registers and byte classification.
`timescale 1ns / 1ps

module ipmi_rxd_front import ipmi_rxd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic [7:0]         rx_byte_i,
  output word_t              word_o,
  output logic               keep_o      // word produces work in the back end
);

  logic       attn_en_q;
  logic       esc_attn_en_q;
  logic [7:0] esc_attn_char_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attn_en_q       <= 1'b0;
      esc_attn_en_q   <= 1'b0;
      esc_attn_char_q <= EscAttnCharRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAttnEnable:    attn_en_q       <= cfg_data_i[0];
        CfgEscAttnEnable: esc_attn_en_q   <= cfg_data_i[0];
        CfgEscAttnChar:   esc_attn_char_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify and pre-decode the escaped form
  always_comb begin
    word_o.raw      = rx_byte_i;
    word_o.esc_attn = esc_attn_en_q && (rx_byte_i == esc_attn_char_q);
    word_o.dec_ok   = 1'b1;
    word_o.dec      = rx_byte_i;
    unique case (rx_byte_i)
      EscStart: word_o.dec = ChStart;
      EscStop:  word_o.dec = ChStop;
      EscHand:  word_o.dec = ChHand;
      EscEsc:   word_o.dec = ChEsc;
      EscAttn:  word_o.dec = ChAttn;
      default:  word_o.dec_ok = 1'b0;
    endcase

    keep_o = 1'b1;
    unique case (rx_byte_i)
      ChStart: word_o.cls = ClsStart;
      ChStop:  word_o.cls = ClsStop;
      ChHand:  word_o.cls = ClsHand;
      ChEsc:   word_o.cls = ClsEsc;
      ChAttn: begin
        // raw attention with reporting off leaves all state alone
        word_o.cls = ClsAttn;
        keep_o     = attn_en_q;
      end
      default: word_o.cls = ClsData;
    endcase
  end

endmodule

// File: hdl/ipmi_rxd_fifo.sv
// Small flop-based queue between front and back end.
`timescale 1ns / 1ps
`include "ipmi_serial_basic_mode_rx_deframer_assert.svh"

module ipmi_rxd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `RXD_ASSERT_ALWAYS(a_cnt_bound, (cnt_q <= DepthC), "fifo count above depth")
  `RXD_ASSERT(a_cnt_push, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1),
              "fifo count did not follow a push")

endmodule

// File: hdl/ipmi_rxd_back.sv
// Back end: frame state, checksum, byte count and the result register.
`timescale 1ns / 1ps
`include "ipmi_serial_basic_mode_rx_deframer_assert.svh"

module ipmi_rxd_back import ipmi_rxd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  word_t word_i,
  output logic  pop_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        netfn_q, netfn_d;
  logic [7:0]        held_q, held_d;
  logic [5:0]        seq_q, seq_d;
  logic              out_valid_q;
  res_t              out_q;
  logic              hit;
  res_t              res;
  logic [7:0]        ch;
  logic              store;

  // Take a word whenever the result register is free or draining
  assign pop_o = valid_i && (!out_valid_q || res_ready_i);

  // Execute one word
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    netfn_d    = netfn_q;
    held_d     = held_q;
    seq_d      = seq_q;
    hit        = 1'b0;
    res        = '0;
    ch         = word_i.raw;
    store      = 1'b0;

    unique case (word_i.cls)
      ClsStart: begin
        hit        = in_frame_q;
        res.kind   = KindProto;
        in_frame_d = 1'b1;
        cnt_d      = '0;
        sum_d      = '0;
        ovf_d      = 1'b0;
        esc_d      = 1'b0;
      end
      ClsStop: begin
        hit        = 1'b1;
        esc_d      = 1'b0;
        in_frame_d = 1'b0;
        if (!in_frame_q || esc_q || ovf_q || (cnt_q < MinFrame)) begin
          res.kind = KindProto;
        end else if (sum_q != '0) begin
          res.kind = KindCsum;
        end else begin
          res.kind       = KindOk;
          res.seq_number = seq_q;
          res.msg_length = cnt_q - HdrTrail;
        end
      end
      ClsHand: begin
        hit      = 1'b1;
        res.kind = KindHand;
        esc_d    = 1'b0;
      end
      ClsEsc: begin
        esc_d = 1'b1;
      end
      ClsAttn: begin
        hit      = 1'b1;
        res.kind = KindAttn;
      end
      ClsData: begin
        if (in_frame_q) begin
          store = 1'b1;
          if (esc_q) begin
            esc_d = 1'b0;
            if (word_i.esc_attn) begin
              hit      = 1'b1;
              res.kind = KindAttn;
              store    = 1'b0;
            end else if (!word_i.dec_ok) begin
              hit      = 1'b1;
              res.kind = KindProto;
              ovf_d    = 1'b1;
              store    = 1'b0;
            end else begin
              ch = word_i.dec;
            end
          end
        end
      end
      default: ;
    endcase

    // Message byte path
    if (store && !ovf_q) begin
      if (cnt_q >= MaxFrame) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + ch;
        if (cnt_q == 9'd1) begin
          netfn_d = ch;
        end else if (cnt_q == 9'd4) begin
          seq_d        = ch[7:2];
          hit          = 1'b1;
          res.kind     = KindData;
          res.out_byte = (netfn_q & LunMask) | {6'd0, ch[1:0]};
        end else if (cnt_q == 9'd5) begin
          held_d = ch;
        end else if (cnt_q >= 9'd6) begin
          held_d       = ch;
          hit          = 1'b1;
          res.kind     = KindData;
          res.out_byte = held_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        in_frame_q  <= in_frame_d;
        esc_q       <= esc_d;
        ovf_q       <= ovf_d;
        cnt_q       <= cnt_d;
        sum_q       <= sum_d;
        out_valid_q <= hit;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      netfn_q <= netfn_d;
      held_q  <= held_d;
      seq_q   <= seq_d;
      if (hit) begin
        out_q <= res;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `RXD_ASSERT(a_start_opens, (pop_o && word_i.cls == ClsStart) |=> in_frame_q,
              "start word did not open a frame")
  `RXD_ASSERT(a_ok_len, (out_valid_q && out_q.kind == KindOk) |->
              ((out_q.msg_length >= 9'd3) && (out_q.msg_length <= MaxFrame - HdrTrail)),
              "frame ok with impossible length")

endmodule

// File: hdl/ipmi_serial_basic_mode_rx_deframer.sv
// Top level of the serial basic-mode receive deframer.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata out_byte, seq_number,
//                                                 msg_length; tuser kind
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the queue has room; a result on m_axis
// goes through the queue and then the result register, which loads when the
// back end takes the word from the queue.
// The queue holds QueueDepth words, so input keeps flowing while a result
// waits; when the queue fills, s_axis_tready drops until m_axis drains.
// Reset is asynchronous and clears frame state and config; no clear pass.
// Config writes are always taken (cfg_ready_o is tied high).
`timescale 1ns / 1ps
`include "ipmi_serial_basic_mode_rx_deframer_assert.svh"

module ipmi_serial_basic_mode_rx_deframer import ipmi_rxd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input bytes
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // [7:0] out_byte, [13:8] seq_number,
                                             // [22:14] msg_length, [23] zero
  output logic [2:0]         m_axis_tuser,   // [2:0] kind
  // config writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned WordW = $bits(word_t);

  word_t            fr_word;
  logic             fr_keep;
  logic             q_full, q_valid, q_pop;
  logic [WordW-1:0] q_rdata;
  word_t            bk_word;
  res_t             res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;

  ipmi_rxd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .word_o      (fr_word),
    .keep_o      (fr_keep)
  );

  ipmi_rxd_fifo #(
    .Width (WordW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid && fr_keep),
    .wdata_i (fr_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign bk_word = word_t'(q_rdata);

  ipmi_rxd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .word_i      (bk_word),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Output packing
  assign m_axis_tdata = {1'b0, res.msg_length, res.seq_number, res.out_byte};
  assign m_axis_tuser = res.kind;

endmodule
